[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");

`endif

[rtl/ionmi_pkg.sv]
package ionmi_pkg;

    localparam logic [7:0] CTRL_RATE_MASK  = 8'hE0;
    localparam logic [2:0] RATE_FIELD_MASK = 3'h7;
    localparam int         SLOT_COUNT      = 4;

    typedef enum logic [1:0] {
        MODE_WR_CTRL = 2'd0,
        MODE_WR_DATA = 2'd1,
        MODE_RD_CTRL = 2'd2,
        MODE_TICK    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0]            read_value;
        logic                  nmi_line;
        logic [SLOT_COUNT-1:0] select_lines;
        logic                  read_write_line;
        logic [SLOT_COUNT-1:0] write_strobes;
        logic [7:0]            write_byte;
        logic                  write_rejected;
    } result_t;

    function automatic logic [2:0] rate_of(input logic [7:0] ctrl);
        return ctrl[7:5] & RATE_FIELD_MASK;
    endfunction

endpackage

[rtl/io_interface_nmi_sequencer_unit.sv]
// Four-slot I/O sequencer with NMI generation. Each request carries a kind in
// s_tuser (control write, data write, control read or one clock tick) and a
// byte in s_tdata, and produces exactly one result on the m_ side with the
// line levels after that request. One request is taken every cycle while the
// result side is not stalled; a request passes through an input register and
// a result register, and the state is updated as the request leaves the input
// register for the result register.
`include "assert_macros.svh"

module io_interface_nmi_sequencer_unit
    import ionmi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] bus_data
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_value, [8] nmi_line, [12:9] select_lines, [13] read_write_line,
    // [17:14] write_strobes, [25:18] write_byte, [26] write_rejected, [31:27] zero
    output logic [31:0] m_tdata
);

    logic       in_valid_reg, in_valid_next;
    mode_t      mode_reg;
    logic [7:0] data_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    result;
    logic       fire;
    logic       s_take;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    ionmi_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (fire),
        .mode      (mode_reg),
        .bus_data  (data_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_take) begin
            mode_reg <= mode_t'(s_tuser);
            data_reg <= s_tdata;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.write_rejected, out_reg.write_byte,
                       out_reg.write_strobes, out_reg.read_write_line,
                       out_reg.select_lines, out_reg.nmi_line, out_reg.read_value};

    // A data write is either delivered to devices or rejected, never both.
    `ASSERT_NEVER(a_reject_excl, aclk, aresetn,
        m_tvalid && out_reg.write_rejected && out_reg.write_strobes != '0)

endmodule

[rtl/ionmi_core.sv]
`include "assert_macros.svh"

module ionmi_core
    import ionmi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_fire,
    input  mode_t      mode,
    input  logic [7:0] bus_data,
    output result_t    result
);

    logic [7:0]            ctrl_reg, ctrl_next;
    logic                  phase_reg, phase_next;
    logic                  stretch_reg, stretch_next;
    logic                  running_reg, running_next;
    logic [7:0]            ticks_reg, ticks_next;
    logic                  nmi_reg, nmi_next;
    logic [SLOT_COUNT-1:0] sel_reg, sel_next;
    logic                  rw_reg, rw_next;
    logic [2:0]            rate_cur;
    logic [2:0]            rate_new;

    always_comb begin
        ctrl_next    = ctrl_reg;
        phase_next   = phase_reg;
        stretch_next = stretch_reg;
        running_next = running_reg;
        ticks_next   = ticks_reg;
        nmi_next     = nmi_reg;
        sel_next     = sel_reg;
        rw_next      = rw_reg;
        rate_cur     = rate_of(ctrl_reg);
        rate_new     = rate_of(bus_data);

        result.read_value     = '0;
        result.write_strobes  = '0;
        result.write_byte     = '0;
        result.write_rejected = 1'b0;

        unique case (mode)
            MODE_WR_CTRL: begin
                ctrl_next = bus_data;
                if ((bus_data & CTRL_RATE_MASK) == 8'h00) begin
                    running_next = 1'b0;
                    ticks_next   = '0;
                    phase_next   = 1'b1;
                    nmi_next     = 1'b0;
                    sel_next     = '0;
                end else begin
                    // Read mode with the timer on drops NMI and holds it low at the next timer expiry.
                    if (bus_data[4]) begin
                        nmi_next     = 1'b0;
                        stretch_next = 1'b1;
                    end else begin
                        stretch_next = 1'b0;
                    end
                    running_next = 1'b1;
                    ticks_next   = phase_reg ? 8'd1 : (8'd1 << rate_new) + 8'd1;
                end
            end
            MODE_WR_DATA: begin
                if (ctrl_reg[4]) begin
                    result.write_rejected = 1'b1;
                end else begin
                    result.write_strobes = ctrl_reg[SLOT_COUNT-1:0];
                    result.write_byte    = bus_data;
                end
            end
            MODE_RD_CTRL: begin
                result.read_value = ctrl_reg;
            end
            MODE_TICK: begin
                if (running_reg) begin
                    if (ticks_reg > 8'd1) begin
                        ticks_next = ticks_reg - 8'd1;
                    end else begin
                        if (phase_reg) begin
                            rw_next = ctrl_reg[4];
                        end
                        nmi_next     = phase_reg && !stretch_reg;
                        stretch_next = 1'b0;
                        sel_next     = phase_reg ? ctrl_reg[SLOT_COUNT-1:0] : '0;
                        phase_next   = !phase_reg;
                        if (rate_cur == 3'd0) begin
                            running_next = 1'b0;
                            ticks_next   = '0;
                        end else begin
                            ticks_next = 8'd1 << (rate_cur - 3'd1);
                        end
                    end
                end
            end
        endcase

        result.nmi_line        = nmi_next;
        result.select_lines    = sel_next;
        result.read_write_line = rw_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            phase_reg   <= 1'b1;
            stretch_reg <= 1'b0;
            running_reg <= 1'b0;
            ticks_reg   <= '0;
            nmi_reg     <= 1'b0;
            sel_reg     <= '0;
            rw_reg      <= 1'b0;
        end else if (item_fire) begin
            ctrl_reg    <= ctrl_next;
            phase_reg   <= phase_next;
            stretch_reg <= stretch_next;
            running_reg <= running_next;
            ticks_reg   <= ticks_next;
            nmi_reg     <= nmi_next;
            sel_reg     <= sel_next;
            rw_reg      <= rw_next;
        end
    end

    // A stopped timer leaves NMI and every chip select low.
    `ASSERT_IMPLIES(a_stopped_quiet, aclk, aresetn, !running_reg, !nmi_reg && sel_reg == '0)
    // A running timer always has a tick count to work down.
    `ASSERT_IMPLIES(a_running_count, aclk, aresetn, running_reg, ticks_reg != 8'd0)

endmodule

[bench/tb_io_interface_nmi_sequencer_unit.sv]
`timescale 1ns / 100ps

module tb_io_interface_nmi_sequencer_unit;
    import ionmi_pkg::*;

    typedef struct {
        mode_t      kind;
        logic [7:0] bus_byte;
        int         idle_after;
    } bus_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    io_interface_nmi_sequencer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the sequencer state.
    logic [7:0] ctrl_reg;
    logic       phase_on;
    logic       stretch_armed;
    logic       timer_on;
    logic [7:0] tick_count;
    logic       nmi_q;
    logic [3:0] sel_q;
    logic       rw_q;

    bus_req_t pending_reqs[$];
    result_t  line_levels_q[$];
    int       total_reqs   = 0;
    int       accepted_cnt = 0;
    int       mismatch_cnt = 0;
    int       gap_left     = 0;
    int       stall_left   = 0;
    int       results_seen = 0;
    logic     hold_req     = 1'b0;

    task automatic sequencer_reset();
        ctrl_reg      = 8'h00;
        phase_on      = 1'b1;
        stretch_armed = 1'b0;
        timer_on      = 1'b0;
        tick_count    = 8'h00;
        nmi_q         = 1'b0;
        sel_q         = 4'h0;
        rw_q          = 1'b0;
    endtask

    task automatic timer_expire();
        if (phase_on)
            rw_q = ctrl_reg[4];
        nmi_q         = phase_on && !stretch_armed;
        stretch_armed = 1'b0;
        sel_q         = phase_on ? ctrl_reg[3:0] : 4'h0;
        phase_on      = !phase_on;
    endtask

    task automatic apply_request(input mode_t kind, input logic [7:0] d, output result_t r);
        logic [2:0] n;
        r = '0;
        case (kind)
            MODE_WR_CTRL: begin
                ctrl_reg = d;
                if ((d & CTRL_RATE_MASK) == 8'h00) begin
                    timer_on   = 1'b0;
                    tick_count = 8'h00;
                    phase_on   = 1'b1;
                    nmi_q      = 1'b0;
                    sel_q      = 4'h0;
                end else begin
                    if (d[4]) begin
                        nmi_q         = 1'b0;
                        stretch_armed = 1'b1;
                    end else begin
                        stretch_armed = 1'b0;
                    end
                    n          = d[7:5];
                    timer_on   = 1'b1;
                    // Starting on the idle phase waits one full timer period plus one tick.
                    tick_count = phase_on ? 8'd1 : 8'((9'd1 << n) + 9'd1);
                end
            end
            MODE_WR_DATA: begin
                if (ctrl_reg[4]) begin
                    r.write_rejected = 1'b1;
                end else begin
                    r.write_strobes = ctrl_reg[3:0];
                    r.write_byte    = d;
                end
            end
            MODE_RD_CTRL: begin
                r.read_value = ctrl_reg;
            end
            default: begin
                if (timer_on) begin
                    if (tick_count > 8'd1) begin
                        tick_count = tick_count - 8'd1;
                    end else begin
                        timer_expire();
                        n = ctrl_reg[7:5];
                        if (n == 3'd0) begin
                            timer_on   = 1'b0;
                            tick_count = 8'h00;
                        end else begin
                            tick_count = 8'd1 << (n - 3'd1);
                        end
                    end
                end
            end
        endcase
        r.nmi_line        = nmi_q;
        r.select_lines    = sel_q;
        r.read_write_line = rw_q;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            if (mismatch_cnt < 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    task automatic add_req(input mode_t kind, input logic [7:0] d, input int idle);
        bus_req_t q;
        q.kind       = kind;
        q.bus_byte   = d;
        q.idle_after = idle;
        pending_reqs.push_back(q);
        total_reqs++;
    endtask

    // Driver: presents pending requests and predicts each one as it is accepted.
    always @(posedge aclk) begin : drive_requests
        bus_req_t nxt;
        result_t  r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                apply_request(mode_t'(s_tuser), s_tdata, r);
                line_levels_q.push_back(r);
                accepted_cnt++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt      = pending_reqs.pop_front();
                s_tuser  <= nxt.kind;
                s_tdata  <= nxt.bus_byte;
                gap_left = nxt.idle_after;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks every result against the oldest expectation and paces m_tready.
    always @(posedge aclk) begin : watch_results
        result_t want;
        int      nxt_stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            nxt_stall = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_tvalid && m_tready) begin
                if (line_levels_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: result with no request outstanding: %h",
                                 $realtime, m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = line_levels_q.pop_front();
                    check_field("read_value",      want.read_value,      m_tdata[7:0]);
                    check_field("nmi_line",        want.nmi_line,        m_tdata[8]);
                    check_field("select_lines",    want.select_lines,    m_tdata[12:9]);
                    check_field("read_write_line", want.read_write_line, m_tdata[13]);
                    check_field("write_strobes",   want.write_strobes,   m_tdata[17:14]);
                    check_field("write_byte",      want.write_byte,      m_tdata[25:18]);
                    check_field("write_rejected",  want.write_rejected,  m_tdata[26]);
                end
                results_seen++;
                // Alternate stretches of random stalls with stretches of none.
                nxt_stall = ((results_seen / 40) % 2 == 0) ? $urandom_range(0, 14) : 0;
            end
            stall_left = nxt_stall;
            m_tready <= (nxt_stall == 0) && !hold_req;
        end
    end

    // Long back-pressure window so the block fills up and stalls its input.
    initial begin
        wait (accepted_cnt >= 200);
        @(posedge aclk);
        hold_req <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_req <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_io_interface_nmi_sequencer_unit: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] d;
        int         pick;
        int         idle;
        sequencer_reset();

        // Directed part: stop/start, both phases, read stretch, rejects, extremes.
        add_req(MODE_RD_CTRL, 8'h00, 0);
        add_req(MODE_WR_DATA, 8'hFF, 1);  // nothing selected, byte still delivered
        add_req(MODE_TICK,    8'hFF, 0);  // tick while stopped
        add_req(MODE_WR_CTRL, 8'h2F, 0);
        add_req(MODE_TICK,    8'h00, 2);
        add_req(MODE_WR_DATA, 8'hA5, 0);
        add_req(MODE_TICK,    8'h00, 0);
        add_req(MODE_WR_CTRL, 8'h3A, 0);  // read mode arms a stretch
        add_req(MODE_WR_DATA, 8'h5A, 0);  // rejected in read mode
        add_req(MODE_TICK,    8'h00, 3);
        add_req(MODE_TICK,    8'h00, 0);
        add_req(MODE_TICK,    8'h00, 0);
        add_req(MODE_WR_CTRL, 8'h45, 0);  // started on the idle phase
        for (int i = 0; i < 5; i++)
            add_req(MODE_TICK, 8'h00, i);
        add_req(MODE_RD_CTRL, 8'hFF, 0);
        add_req(MODE_WR_CTRL, 8'h00, 0);  // stop
        add_req(MODE_TICK,    8'h00, 0);
        add_req(MODE_WR_CTRL, 8'hE3, 0);
        add_req(MODE_WR_CTRL, 8'hFF, 0);
        add_req(MODE_WR_DATA, 8'h00, 0);
        add_req(MODE_RD_CTRL, 8'h00, 14);

        // Random part: mostly ticks so the timer runs through many firings.
        for (int i = 0; i < 600; i++) begin
            idle = ((i / 50) % 2 == 0) ? $urandom_range(0, 14) : 0;
            d    = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    d[7:5] = 3'd0;
                else if (pick < 7)
                    d[7:5] = 3'($urandom_range(1, 3));
                else
                    d[7:5] = 3'($urandom_range(4, 7));
                add_req(MODE_WR_CTRL, d, idle);
            end else if (pick < 30) begin
                add_req(MODE_WR_DATA, d, idle);
            end else if (pick < 42) begin
                add_req(MODE_RD_CTRL, d, idle);
            end else begin
                add_req(MODE_TICK, d, idle);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (accepted_cnt == total_reqs);
        wait (line_levels_q.size() == 0);
        repeat (20) @(posedge aclk);

        if (mismatch_cnt == 0 && line_levels_q.size() == 0) begin
            $display("tb_io_interface_nmi_sequencer_unit: done, clean");
        end else begin
            $display("tb_io_interface_nmi_sequencer_unit: done, errors");
        end
        $finish;
    end

endmodule

[io_interface_nmi_sequencer_unit.f]
+incdir+rtl
rtl/ionmi_pkg.sv
rtl/ionmi_core.sv
rtl/io_interface_nmi_sequencer_unit.sv
bench/tb_io_interface_nmi_sequencer_unit.sv
